>>> design/cbse_pkg.sv
`default_nettype none

package cbse_pkg;

  // Field and register widths
  localparam int COORD_W    = 16;
  localparam int FACTOR_W   = 17;
  localparam int LE_W       = 16;
  localparam int MINW_W     = 15;
  localparam int CUT_W      = 16;
  localparam int SCALE_W    = 31;
  localparam int WEIGHT_W   = 17;
  localparam int GRAD_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Linear factors, in the order em, ep, xm, xp
  localparam int N_FACTORS = 4;
  localparam int F_EM      = 0;
  localparam int F_EP      = 1;
  localparam int F_XM      = 2;
  localparam int F_XP      = 3;

  // Datapath widths
  localparam int WPROD_W    = 2 * FACTOR_W;
  localparam int FL_W       = 31;
  localparam int FS_W       = FACTOR_W + SCALE_W;
  localparam int GRAD_SHIFT = 17;
  localparam int NORM_W     = FS_W - GRAD_SHIFT;
  localparam int NUM_W      = FL_W + SCALE_W;
  localparam int DVD_W      = NUM_W + 1 - GRAD_SHIFT;

  // Attenuation divider: quotient bits retired per stage
  localparam int QUOT_W             = 32;
  localparam int REM_W              = CUT_W;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = QUOT_W / DIV_BITS_PER_STAGE;

  // Stages ahead of the divider, then divider load stage, divider, output register
  localparam int FRONT_STAGES = 4;
  localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + 2;

  // Fixed-point constants, Q1.16
  localparam logic [FACTOR_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [FACTOR_W-1:0] HALF_Q16 = 17'd32768;

  localparam logic [GRAD_W-1:0] GRAD_POS_MAX     = 32'h7FFF_FFFF;
  localparam logic [GRAD_W-1:0] GRAD_NEG_MAG_MAX = 32'h8000_0000;

  // Register reset values
  localparam logic [MINW_W-1:0]  MIN_WEIGHT_RST = 15'd7;
  localparam logic [CUT_W-1:0]   CUT_LENGTH_RST = 16'd3277;
  localparam logic [SCALE_W-1:0] SCALE_RST      = 31'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_WEIGHT = 2'd0,
    REG_CUT_LENGTH = 2'd1,
    REG_XI_SCALE   = 2'd2,
    REG_ETA_SCALE  = 2'd3
  } cfg_reg_t;

  typedef logic [FACTOR_W-1:0] factor_t;
  typedef logic [LE_W-1:0]     le_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [QUOT_W-1:0] dq;
  } div_state_t;

endpackage

`default_nettype wire

>>> design/clamped_bilinear_shape_eval.sv
// Clamped bilinear shape-function evaluator for a four-node quad.
//
// Input channel: raise start with xi_coord and eta_coord (signed Q2.14). A
// beat is taken at each rising edge with start high and busy low; busy is
// never raised, so one particle may enter in every cycle.
// Result channel: done pulses for one cycle with the four weights (Q1.16)
// and eight gradients (Q16.16) of one particle. The receiver cannot stall,
// so results leave in input order with no holding stage.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while no particle is in flight.
// Throughput one particle per cycle. Four front stages form factors,
// weights and products; the attenuation divider (one per gradient
// magnitude) retires two quotient bits per stage over 16 stages after a
// load stage; one output stage then applies signs and saturation.
// Reset (synchronous rst) drops every particle in flight and restores the
// register defaults.

`default_nettype none

module clamped_bilinear_shape_eval import cbse_pkg::*; (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  output logic                       busy,
  input  wire  signed [COORD_W-1:0]  xi_coord,
  input  wire  signed [COORD_W-1:0]  eta_coord,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire  [CFG_IDX_W-1:0]       cfg_index,
  input  wire  [CFG_DATA_W-1:0]      cfg_data,
  output logic                       done,
  output logic [WEIGHT_W-1:0]        weight_one,
  output logic [WEIGHT_W-1:0]        weight_two,
  output logic [WEIGHT_W-1:0]        weight_three,
  output logic [WEIGHT_W-1:0]        weight_four,
  output logic signed [GRAD_W-1:0]   grad_one_x,
  output logic signed [GRAD_W-1:0]   grad_one_y,
  output logic signed [GRAD_W-1:0]   grad_two_x,
  output logic signed [GRAD_W-1:0]   grad_two_y,
  output logic signed [GRAD_W-1:0]   grad_three_x,
  output logic signed [GRAD_W-1:0]   grad_three_y,
  output logic signed [GRAD_W-1:0]   grad_four_x,
  output logic signed [GRAD_W-1:0]   grad_four_y
);

  localparam logic signed [FACTOR_W:0] HALF_S = 18'sd32768;

  // Clamp a raw factor to [lo, 1 - lo]
  function automatic factor_t clamp_factor(input logic signed [FACTOR_W:0] raw,
                                           input logic signed [FACTOR_W:0] lo);
    logic signed [FACTOR_W:0] hi;
    logic signed [FACTOR_W:0] sel;
    hi = 18'sd65536 - lo;
    if (raw < lo) begin
      sel = lo;
    end else if (raw > hi) begin
      sel = hi;
    end else begin
      sel = raw;
    end
    return sel[FACTOR_W-1:0];
  endfunction

  // One restoring division step: shift in a dividend bit, retire a quotient bit
  function automatic div_state_t div_step(input div_state_t st,
                                          input logic [CUT_W-1:0] den);
    logic [REM_W:0] trial;
    logic           ge;
    div_state_t     res;
    trial   = {st.rem, st.dq[QUOT_W-1]};
    ge      = (trial >= {1'b0, den});
    res.dq  = {st.dq[QUOT_W-2:0], ge};
    if (ge) begin
      res.rem = REM_W'(trial - {1'b0, den});
    end else begin
      res.rem = trial[REM_W-1:0];
    end
    return res;
  endfunction

  // Configuration registers
  logic [MINW_W-1:0]  min_weight;
  logic [CUT_W-1:0]   cut_length;
  logic [SCALE_W-1:0] xi_scale;
  logic [SCALE_W-1:0] eta_scale;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_weight <= MIN_WEIGHT_RST;
      cut_length <= CUT_LENGTH_RST;
      xi_scale   <= SCALE_RST;
      eta_scale  <= SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_WEIGHT: min_weight <= cfg_data[MINW_W-1:0];
        REG_CUT_LENGTH: cut_length <= cfg_data[CUT_W-1:0];
        REG_XI_SCALE:   xi_scale   <= cfg_data[SCALE_W-1:0];
        REG_ETA_SCALE:  eta_scale  <= cfg_data[SCALE_W-1:0];
      endcase
    end
  end

  // Scale per gradient magnitude: eta factors feed x gradients
  logic [SCALE_W-1:0] unit_scale [N_FACTORS];

  always_comb begin
    for (int k = 0; k < N_FACTORS; k++) begin
      unit_scale[k] = (k == F_EM || k == F_EP) ? xi_scale : eta_scale;
    end
  end

  // Stage 1: raw linear factors and clamp
  logic signed [FACTOR_W:0] xi_dbl;
  logic signed [FACTOR_W:0] eta_dbl;
  logic signed [FACTOR_W:0] min_lo;
  logic signed [FACTOR_W:0] raw [N_FACTORS];

  assign xi_dbl  = {xi_coord[COORD_W-1], xi_coord, 1'b0};
  assign eta_dbl = {eta_coord[COORD_W-1], eta_coord, 1'b0};
  assign min_lo  = {3'b000, min_weight};

  always_comb begin
    raw[F_EM] = HALF_S - eta_dbl;
    raw[F_EP] = HALF_S + eta_dbl;
    raw[F_XM] = HALF_S - xi_dbl;
    raw[F_XP] = HALF_S + xi_dbl;
  end

  logic    s1_valid;
  factor_t s1_f [N_FACTORS];

  always_ff @(posedge clk) begin
    for (int k = 0; k < N_FACTORS; k++) begin
      s1_f[k] <= clamp_factor(raw[k], min_lo);
    end
  end

  // Stage 2: distance to the nearer edge, attenuation flag, weight products
  le_t                  le_c    [N_FACTORS];
  logic [N_FACTORS-1:0] att_c;
  logic [WPROD_W-1:0]   wprod_c [N_FACTORS];

  always_comb begin
    for (int k = 0; k < N_FACTORS; k++) begin
      if (s1_f[k] <= HALF_Q16) begin
        le_c[k] = s1_f[k][LE_W-1:0];
      end else begin
        le_c[k] = LE_W'(ONE_Q16 - s1_f[k]);
      end
      att_c[k] = (le_c[k] < cut_length);
    end
    wprod_c[0] = WPROD_W'(s1_f[F_XM]) * WPROD_W'(s1_f[F_EM]);
    wprod_c[1] = WPROD_W'(s1_f[F_XP]) * WPROD_W'(s1_f[F_EM]);
    wprod_c[2] = WPROD_W'(s1_f[F_XP]) * WPROD_W'(s1_f[F_EP]);
    wprod_c[3] = WPROD_W'(s1_f[F_XM]) * WPROD_W'(s1_f[F_EP]);
  end

  logic                 s2_valid;
  factor_t              s2_f     [N_FACTORS];
  le_t                  s2_le    [N_FACTORS];
  logic [N_FACTORS-1:0] s2_att;
  logic [WPROD_W-1:0]   s2_wprod [N_FACTORS];

  always_ff @(posedge clk) begin
    s2_f     <= s1_f;
    s2_le    <= le_c;
    s2_att   <= att_c;
    s2_wprod <= wprod_c;
  end

  // Stage 3: factor times distance, factor times scale, round the weights
  logic [FACTOR_W+LE_W-1:0] fl_full [N_FACTORS];
  logic [FS_W-1:0]          fs_c    [N_FACTORS];
  logic [WPROD_W-1:0]       wround  [N_FACTORS];

  always_comb begin
    for (int k = 0; k < N_FACTORS; k++) begin
      fl_full[k] = (FACTOR_W+LE_W)'(s2_f[k]) * (FACTOR_W+LE_W)'(s2_le[k]);
      fs_c[k]    = FS_W'(s2_f[k]) * FS_W'(unit_scale[k]);
      wround[k]  = s2_wprod[k] + WPROD_W'(HALF_Q16);
    end
  end

  logic                 s3_valid;
  logic [FL_W-1:0]      s3_fl  [N_FACTORS];
  logic [FS_W-1:0]      s3_fs  [N_FACTORS];
  weight_t              s3_w   [N_FACTORS];
  logic [N_FACTORS-1:0] s3_att;

  always_ff @(posedge clk) begin
    for (int k = 0; k < N_FACTORS; k++) begin
      s3_fl[k] <= fl_full[k][FL_W-1:0];
      s3_w[k]  <= wround[k][WEIGHT_W+15:16];
    end
    s3_fs  <= fs_c;
    s3_att <= s2_att;
  end

  // Stage 4: full attenuated numerator, rounded plain magnitude
  logic [NUM_W-1:0] num_c    [N_FACTORS];
  logic [FS_W-1:0]  fs_round [N_FACTORS];

  always_comb begin
    for (int k = 0; k < N_FACTORS; k++) begin
      num_c[k]    = NUM_W'(s3_fl[k]) * NUM_W'(unit_scale[k]);
      fs_round[k] = s3_fs[k] + FS_W'(ONE_Q16);
    end
  end

  logic                 s4_valid;
  logic [NUM_W-1:0]     s4_num  [N_FACTORS];
  logic [NORM_W-1:0]    s4_norm [N_FACTORS];
  weight_t              s4_w    [N_FACTORS];
  logic [N_FACTORS-1:0] s4_att;

  always_ff @(posedge clk) begin
    for (int k = 0; k < N_FACTORS; k++) begin
      s4_norm[k] <= fs_round[k][FS_W-1:GRAD_SHIFT];
    end
    s4_num <= num_c;
    s4_w   <= s3_w;
    s4_att <= s3_att;
  end

  // Divider load: add half the divisor, drop the 2^17, split off the top bits
  logic [NUM_W:0]   dsum     [N_FACTORS];
  logic [DVD_W-1:0] dividend [N_FACTORS];
  div_state_t       div_load [N_FACTORS];

  always_comb begin
    for (int k = 0; k < N_FACTORS; k++) begin
      dsum[k]         = (NUM_W+1)'(s4_num[k]) + (NUM_W+1)'({cut_length, 16'b0});
      dividend[k]     = dsum[k][NUM_W:GRAD_SHIFT];
      div_load[k].rem = REM_W'(dividend[k][DVD_W-1:QUOT_W]);
      div_load[k].dq  = dividend[k][QUOT_W-1:0];
    end
  end

  // Divider pipeline: stage 0 holds the loaded operands
  logic [DIV_STAGES:0]  dv_valid;
  div_state_t           dv_div   [DIV_STAGES+1][N_FACTORS];
  logic [NORM_W-1:0]    dv_norm  [DIV_STAGES+1][N_FACTORS];
  weight_t              dv_w     [DIV_STAGES+1][N_FACTORS];
  logic [N_FACTORS-1:0] dv_att   [DIV_STAGES+1];
  div_state_t           div_next [1:DIV_STAGES][N_FACTORS];

  always_comb begin
    div_state_t st;
    for (int j = 1; j <= DIV_STAGES; j++) begin
      for (int k = 0; k < N_FACTORS; k++) begin
        st = dv_div[j-1][k];
        for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
          st = div_step(st, cut_length);
        end
        div_next[j][k] = st;
      end
    end
  end

  always_ff @(posedge clk) begin
    dv_div[0]  <= div_load;
    dv_norm[0] <= s4_norm;
    dv_w[0]    <= s4_w;
    dv_att[0]  <= s4_att;
    for (int j = 1; j <= DIV_STAGES; j++) begin
      dv_div[j]  <= div_next[j];
      dv_norm[j] <= dv_norm[j-1];
      dv_w[j]    <= dv_w[j-1];
      dv_att[j]  <= dv_att[j-1];
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      dv_valid <= '0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      dv_valid <= {dv_valid[DIV_STAGES-1:0], s4_valid};
      done     <= dv_valid[DIV_STAGES];
    end
  end

  // Output stage: choose magnitude, apply sign, saturate
  logic [GRAD_W-1:0] mag     [N_FACTORS];
  logic [GRAD_W-1:0] pos_val [N_FACTORS];
  logic [GRAD_W-1:0] neg_val [N_FACTORS];

  always_comb begin
    for (int k = 0; k < N_FACTORS; k++) begin
      if (dv_att[DIV_STAGES][k]) begin
        mag[k] = dv_div[DIV_STAGES][k].dq;
      end else begin
        mag[k] = GRAD_W'(dv_norm[DIV_STAGES][k]);
      end
      pos_val[k] = (mag[k] > GRAD_POS_MAX) ? GRAD_POS_MAX : mag[k];
      neg_val[k] = '0 - ((mag[k] > GRAD_NEG_MAG_MAX) ? GRAD_NEG_MAG_MAX : mag[k]);
    end
  end

  always_ff @(posedge clk) begin
    weight_one   <= dv_w[DIV_STAGES][0];
    weight_two   <= dv_w[DIV_STAGES][1];
    weight_three <= dv_w[DIV_STAGES][2];
    weight_four  <= dv_w[DIV_STAGES][3];
    grad_one_x   <= neg_val[F_EM];
    grad_one_y   <= neg_val[F_XM];
    grad_two_x   <= pos_val[F_EM];
    grad_two_y   <= neg_val[F_XP];
    grad_three_x <= pos_val[F_EP];
    grad_three_y <= pos_val[F_XP];
    grad_four_x  <= neg_val[F_EP];
    grad_four_y  <= pos_val[F_XM];
  end

endmodule

`default_nettype wire

>>> design/cbse_checker.sv
`default_nettype none

module cbse_checker import cbse_pkg::*; (
  input wire                       clk,
  input wire                       rst,
  input wire                       start,
  input wire                       busy,
  input wire                       done,
  input wire [WEIGHT_W-1:0]        weight_one,
  input wire [WEIGHT_W-1:0]        weight_two,
  input wire [WEIGHT_W-1:0]        weight_three,
  input wire [WEIGHT_W-1:0]        weight_four,
  input wire signed [GRAD_W-1:0]   grad_one_x,
  input wire signed [GRAD_W-1:0]   grad_one_y,
  input wire signed [GRAD_W-1:0]   grad_two_x,
  input wire signed [GRAD_W-1:0]   grad_two_y,
  input wire signed [GRAD_W-1:0]   grad_three_x,
  input wire signed [GRAD_W-1:0]   grad_three_y,
  input wire signed [GRAD_W-1:0]   grad_four_x,
  input wire signed [GRAD_W-1:0]   grad_four_y
);

  logic [WEIGHT_W+1:0] weight_sum;
  logic [GRAD_W-1:0]   x_pair_a;
  logic [GRAD_W-1:0]   x_pair_b;
  logic [GRAD_W-1:0]   y_pair_a;
  logic [GRAD_W-1:0]   y_pair_b;

  // Weights form a partition of unity up to four rounding steps
  assign weight_sum = (WEIGHT_W+2)'(weight_one) + (WEIGHT_W+2)'(weight_two)
                    + (WEIGHT_W+2)'(weight_three) + (WEIGHT_W+2)'(weight_four);

  // Gradients sharing a factor come in opposite-sign pairs
  assign x_pair_a = GRAD_W'(grad_one_x + grad_two_x);
  assign x_pair_b = GRAD_W'(grad_three_x + grad_four_x);
  assign y_pair_a = GRAD_W'(grad_one_y + grad_four_y);
  assign y_pair_b = GRAD_W'(grad_two_y + grad_three_y);

  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted beat gave no result after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching input beat");

  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (weight_sum >= 19'd65535 && weight_sum <= 19'd65538))
    else $error("nodal weights do not sum to one");

  a_grad_pairs: assert property (@(posedge clk) disable iff (rst)
    done |-> (x_pair_a == '0 && x_pair_b == '0 && y_pair_a == '0 && y_pair_b == '0))
    else $error("paired gradients are not opposite in sign");

endmodule

bind clamped_bilinear_shape_eval cbse_checker u_cbse_checker (.*);

`default_nettype wire

>>> sim/clamped_bilinear_shape_eval_test.sv
module clamped_bilinear_shape_eval_test;
  import cbse_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic [WEIGHT_W-1:0] weight [4];
    logic [GRAD_W-1:0]   grad [8];
  } shape_result_t;

  // Predict weights and gradients per particle beat and check results in order
  class shape_scoreboard;
    logic [MINW_W-1:0]  min_weight;
    logic [CUT_W-1:0]   cut_length;
    logic [SCALE_W-1:0] xi_scale;
    logic [SCALE_W-1:0] eta_scale;
    shape_result_t      expected_shapes [$];
    int                 errors;

    function new();
      errors = 0;
      restore_defaults();
    endfunction

    function void restore_defaults();
      min_weight = MIN_WEIGHT_RST;
      cut_length = CUT_LENGTH_RST;
      xi_scale   = SCALE_RST;
      eta_scale  = SCALE_RST;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MIN_WEIGHT: min_weight = data[MINW_W-1:0];
        REG_CUT_LENGTH: cut_length = data[CUT_W-1:0];
        REG_XI_SCALE:   xi_scale   = data[SCALE_W-1:0];
        REG_ETA_SCALE:  eta_scale  = data[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // Clamp a linear factor to [min_weight, 1 - min_weight]
    function factor_t clamp_lin(int f);
      int lo;
      int hi;
      lo = int'(min_weight);
      hi = 65536 - lo;
      if (f < lo) return factor_t'(lo);
      if (f > hi) return factor_t'(hi);
      return factor_t'(f);
    endfunction

    function weight_t corner_weight(factor_t a, factor_t b);
      logic [63:0] prod;
      prod = 64'(a) * 64'(b);
      return weight_t'((prod + 64'd32768) >> 16);
    endfunction

    // Half-scale times factor, attenuated near zero and one, rounded on magnitude
    function logic [GRAD_W-1:0] node_gradient(factor_t f, logic [SCALE_W-1:0] s, bit neg);
      logic [63:0] offset;
      logic [63:0] le;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] mag;
      offset = (f > HALF_Q16) ? 64'(f) - 64'(HALF_Q16) : 64'(HALF_Q16) - 64'(f);
      le = (offset > 64'd32768) ? 64'd0 : 64'd32768 - offset;
      if (le < 64'(cut_length)) begin
        num = 64'(f) * 64'(s) * le;
        den = 64'(cut_length) << GRAD_SHIFT;
        mag = (num + (den >> 1)) / den;
      end else begin
        mag = (64'(f) * 64'(s) + 64'd65536) >> GRAD_SHIFT;
      end
      if (neg) begin
        if (mag > 64'h8000_0000) mag = 64'h8000_0000;
        return 32'd0 - mag[31:0];
      end
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return mag[31:0];
    endfunction

    function shape_result_t predict_shape(logic signed [COORD_W-1:0] xi,
                                          logic signed [COORD_W-1:0] eta);
      int c_xi;
      int c_eta;
      factor_t xm, xp, em, ep;
      shape_result_t r;
      c_xi  = int'(xi);
      c_eta = int'(eta);
      xm = clamp_lin(32768 - 2 * c_xi);
      xp = clamp_lin(32768 + 2 * c_xi);
      em = clamp_lin(32768 - 2 * c_eta);
      ep = clamp_lin(32768 + 2 * c_eta);
      r.weight[0] = corner_weight(xm, em);
      r.weight[1] = corner_weight(xp, em);
      r.weight[2] = corner_weight(xp, ep);
      r.weight[3] = corner_weight(xm, ep);
      r.grad[0] = node_gradient(em, xi_scale, 1'b1);
      r.grad[1] = node_gradient(xm, eta_scale, 1'b1);
      r.grad[2] = node_gradient(em, xi_scale, 1'b0);
      r.grad[3] = node_gradient(xp, eta_scale, 1'b1);
      r.grad[4] = node_gradient(ep, xi_scale, 1'b0);
      r.grad[5] = node_gradient(xp, eta_scale, 1'b0);
      r.grad[6] = node_gradient(ep, xi_scale, 1'b1);
      r.grad[7] = node_gradient(xm, eta_scale, 1'b0);
      return r;
    endfunction

    function void note_particle(logic signed [COORD_W-1:0] xi,
                                logic signed [COORD_W-1:0] eta);
      expected_shapes.insert(expected_shapes.size(), predict_shape(xi, eta));
    endfunction

    function int pending();
      return expected_shapes.size();
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_shape(shape_result_t got);
      shape_result_t want;
      if (expected_shapes.size() == 0) begin
        report_mismatch("result beat with no particle outstanding");
        return;
      end
      want = expected_shapes.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got.weight[i] !== want.weight[i])
          report_mismatch($sformatf("weight %0d got %0d want %0d",
                                    i + 1, got.weight[i], want.weight[i]));
      end
      for (int i = 0; i < 8; i++) begin
        if (got.grad[i] !== want.grad[i])
          report_mismatch($sformatf("grad %0d %s got %0d want %0d", i / 2 + 1,
                                    (i % 2) ? "y" : "x", $signed(got.grad[i]),
                                    $signed(want.grad[i])));
      end
    endtask
  endclass

  logic                       clk;
  logic                       rst;
  logic                       start;
  wire                        busy;
  logic signed [COORD_W-1:0]  xi_coord;
  logic signed [COORD_W-1:0]  eta_coord;
  logic                       cfg_valid;
  wire                        cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  wire                        done;
  wire [WEIGHT_W-1:0]         weight_one, weight_two, weight_three, weight_four;
  wire signed [GRAD_W-1:0]    grad_one_x, grad_one_y, grad_two_x, grad_two_y;
  wire signed [GRAD_W-1:0]    grad_three_x, grad_three_y, grad_four_x, grad_four_y;

  shape_scoreboard sb = new();
  int              quiet_cycles;

  clamped_bilinear_shape_eval i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Capture each result beat and hand it to the scoreboard
  always @(posedge clk) begin
    shape_result_t got;
    if (!rst && done) begin
      got.weight[0] = weight_one;
      got.weight[1] = weight_two;
      got.weight[2] = weight_three;
      got.weight[3] = weight_four;
      got.grad[0] = grad_one_x;
      got.grad[1] = grad_one_y;
      got.grad[2] = grad_two_x;
      got.grad[3] = grad_two_y;
      got.grad[4] = grad_three_x;
      got.grad[5] = grad_three_y;
      got.grad[6] = grad_four_x;
      got.grad[7] = grad_four_y;
      sb.check_shape(got);
    end
  end

  // Abort when no beat of any kind moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("clamped_bilinear_shape_eval verification failed");
        $finish;
      end
    end
  end

  // Mix full-range, interior, near-corner and edge coordinates
  function automatic logic signed [COORD_W-1:0] pick_coord();
    int v;
    case ($urandom_range(0, 5))
      0, 1: v = int'($urandom);
      2: v = int'($urandom_range(0, 32768)) - 16384;
      3: v = ($urandom_range(0, 1) ? 16384 : -16384) + int'($urandom_range(0, 4096)) - 2048;
      4: v = ($urandom_range(0, 1) ? 14746 : -14746) + int'($urandom_range(0, 64)) - 32;
      default: begin
        case ($urandom_range(0, 6))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = 16384;
          4: v = -16384;
          5: v = 1;
          default: v = -1;
        endcase
      end
    endcase
    return COORD_W'(v);
  endfunction

  task automatic send_particle(logic signed [COORD_W-1:0] xi, logic signed [COORD_W-1:0] eta);
    @(negedge clk);
    start = 1'b1;
    xi_coord = xi;
    eta_coord = eta;
    do @(posedge clk); while (busy);
    sb.note_particle(xi, eta);
  endtask

  // Hold start low over an idle gap with junk on the coordinate ports
  task automatic idle_gap(int n);
    @(negedge clk);
    start = 1'b0;
    xi_coord = COORD_W'($urandom);
    eta_coord = COORD_W'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic stop_particles();
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic run_particles(int count, bit idling);
    bit gaps_now;
    gaps_now = 1'b0;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) gaps_now = idling && ($urandom_range(0, 1) == 1);
      if (gaps_now && $urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 9));
      send_particle(pick_coord(), pick_coord());
    end
    stop_particles();
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic program_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data = $urandom;
  endtask

  // Write all four registers, with junk above each register's width
  task automatic apply_setting(logic [MINW_W-1:0] mw, logic [CUT_W-1:0] cut,
                               logic [SCALE_W-1:0] xs, logic [SCALE_W-1:0] es);
    drain();
    program_reg(REG_MIN_WEIGHT, {17'($urandom), mw});
    program_reg(REG_CUT_LENGTH, {16'($urandom), cut});
    program_reg(REG_XI_SCALE, {1'($urandom), xs});
    program_reg(REG_ETA_SCALE, {1'($urandom), es});
  endtask

  function automatic logic [SCALE_W-1:0] pick_scale();
    if ($urandom_range(0, 1)) return SCALE_W'($urandom_range(1, 1 << 20));
    return SCALE_W'($urandom);
  endfunction

  initial begin
    int dir_xi [18] = '{0, -32768, 32767, -32768, 32767, 16384, -16384, 16384, 16383,
                        16380, 16381, 14745, 14746, 8192, 1, 20000, -1, 0};
    int dir_eta [18] = '{0, -32768, 32767, 32767, -32768, 16384, -16384, -16384, -16383,
                         0, 0, -14746, 14745, -8192, -1, -25000, 1, 16384};
    rst = 1'b1;
    start = 1'b0;
    xi_coord = '0;
    eta_coord = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MIN_WEIGHT;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Directed corners, clamp edges and attenuation edges at reset settings
    for (int k = 0; k < 18; k++) send_particle(COORD_W'(dir_xi[k]), COORD_W'(dir_eta[k]));
    stop_particles();
    run_particles(250, 1'b1);

    // Zero clamp with cut at one half, extreme scales
    apply_setting('0, 16'd32768, 31'd1, 31'h7FFF_FFFF);
    run_particles(200, 1'b1);

    // Widest clamp, tiny cut length, scales swapped
    apply_setting(15'h7FFF, 16'd1, 31'h7FFF_FFFF, 31'd1);
    run_particles(150, 1'b1);

    // Zero cut length and zero scales
    apply_setting('0, '0, '0, '0);
    run_particles(100, 1'b1);

    // Cut length above one half: attenuate everywhere
    apply_setting(MINW_W'($urandom_range(0, 64)), 16'hFFFF, pick_scale(), pick_scale());
    run_particles(200, 1'b1);

    repeat (4) begin
      apply_setting($urandom_range(0, 1) ? MINW_W'($urandom_range(0, 2048)) : MINW_W'($urandom),
                    $urandom_range(0, 3) != 0 ? CUT_W'($urandom_range(1, 32768))
                                              : CUT_W'($urandom),
                    pick_scale(), pick_scale());
      run_particles(200, 1'b1);
    end

    // Back to the default clamp and cut length, run back to back to the end
    apply_setting(MIN_WEIGHT_RST, CUT_LENGTH_RST, pick_scale(), pick_scale());
    run_particles(200, 1'b0);

    drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.errors == 0)
      $display("clamped_bilinear_shape_eval verification clean");
    else
      $display("clamped_bilinear_shape_eval verification failed");
    $finish;
  end

endmodule
